// File: rtl/core/tcce_pkg.sv
// Shared constants for the text console character engine.
// No dependencies; every other file of the block imports this package.
package tcce_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;

endpackage

// File: rtl/core/tcce_if.sv
// Valid/ready channels of the text console character engine.
// Depends on tcce_pkg for the field widths.
interface tcce_cmd_if import tcce_pkg::*;;
    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;

    modport source (output valid, command, char_code, read_row, read_col, input ready);
    modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcce_res_if import tcce_pkg::*;;
    logic             valid;
    logic             ready;
    logic [7:0]       cell_char;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             scrolled;

    modport source (output valid, cell_char, cursor_col, cursor_row, scrolled, input ready);
    modport sink   (input valid, cell_char, cursor_col, cursor_row, scrolled, output ready);
endinterface

// File: rtl/core/text_console_char_engine.sv
// Text console character engine: cursor logic, text store and sweep sequencer.
// Depends on tcce_pkg and the channel interfaces in tcce_if.sv.

// Each command word yields one result word. A put of an ordinary or control
// character and a no-operation answer directly; a read goes through ST_READ
// because the text store read port is registered; a put that scrolls blanks the
// whole new bottom row one cell per cycle in ST_SCROLL, and a clear sweeps the
// whole store in ST_CLEAR. After reset the same sweep runs before the first
// command word is taken; configuration writes are accepted during it. All stores
// go through one write port, the sweeps take their write address from a single
// address counter, and the block takes no new command until the result word of
// the previous one is in the output register and the register is free.
module text_console_char_engine
    import tcce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_wdata,
    tcce_cmd_if.sink     cmd,
    tcce_res_if.source   res
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(MAX_COLS - 1);

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  scroll_row_reg, scroll_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic              in_area_reg, in_area_next;
    logic [7:0]        cols_reg;
    logic [6:0]        rows_reg;

    logic              res_valid_reg, res_valid_next;
    logic [7:0]        res_cell_reg, res_cell_next;
    logic [COL_W-1:0]  res_col_reg, res_col_next;
    logic [ROW_W-1:0]  res_row_reg, res_row_next;
    logic              res_scr_reg, res_scr_next;

    logic [7:0]        mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;

    logic [7:0]        eff_cols;
    logic [6:0]        eff_rows;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic [7:0]        col_inc;
    logic [COL_W-1:0]  put_col;
    logic [6:0]        put_row;
    logic              put_we;
    logic [COL_W-1:0]  put_wcol;
    logic [7:0]        put_wdata;
    logic              put_scroll;
    logic [ROW_W-1:0]  row_fin;
    logic              printable;
    logic              accept;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);

    assign res.valid      = res_valid_reg;
    assign res.cell_char  = res_cell_reg;
    assign res.cursor_col = res_col_reg;
    assign res.cursor_row = res_row_reg;
    assign res.scrolled   = res_scr_reg;

    // Register values outside the meaningful range act as the nearest bound.
    always_comb
    begin
        if (cols_reg == 8'd0)
            eff_cols = 8'd1;
        else if (cols_reg > 8'(MAX_COLS))
            eff_cols = 8'(MAX_COLS);
        else
            eff_cols = cols_reg;

        if (rows_reg == 7'd0)
            eff_rows = 7'd1;
        else if (rows_reg > 7'(MAX_ROWS))
            eff_rows = 7'(MAX_ROWS);
        else
            eff_rows = rows_reg;
    end

    // The cursor is pulled back into the area before every command.
    assign col_c = ({1'b0, cur_col_reg} >= eff_cols) ? COL_W'(eff_cols - 8'd1) : cur_col_reg;
    assign row_c = ({1'b0, cur_row_reg} >= eff_rows) ? ROW_W'(eff_rows - 7'd1) : cur_row_reg;
    assign col_inc = {1'b0, col_c} + 8'd1;
    assign printable = !cmd.char_code[7] && (cmd.char_code[6:5] != 2'b00);

    always_comb
    begin
        put_col   = col_c;
        put_row   = {1'b0, row_c};
        put_we    = 1'b0;
        put_wcol  = col_c;
        put_wdata = CH_SPACE;
        if (cmd.char_code == CH_LF)
        begin
            put_col = '0;
            put_row = {1'b0, row_c} + 7'd1;
        end
        else if (cmd.char_code == CH_CR)
        begin
            put_col = '0;
        end
        else if (cmd.char_code == CH_BS)
        begin
            if (col_c != '0)
            begin
                put_col  = col_c - COL_W'(1);
                put_we   = 1'b1;
                put_wcol = col_c - COL_W'(1);
            end
        end
        else if (printable)
        begin
            put_we    = 1'b1;
            put_wdata = cmd.char_code;
            if (col_inc >= eff_cols)
            begin
                put_col = '0;
                put_row = {1'b0, row_c} + 7'd1;
            end
            else
            begin
                put_col = col_inc[COL_W-1:0];
            end
        end
        put_scroll = (put_row >= eff_rows);
        row_fin    = put_scroll ? ROW_W'(eff_rows - 7'd1) : put_row[ROW_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        top_next        = top_reg;
        scroll_row_next = scroll_row_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        in_area_next    = in_area_reg;
        res_valid_next  = res_valid_reg;
        res_cell_next   = res_cell_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        res_scr_next    = res_scr_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_reg;
        mem_wdata       = CH_SPACE;
        rd_addr         = {ROW_W'(top_reg + cmd.read_row), cmd.read_col};

        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == SWEEP_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_col_next = col_c;
                    cur_row_next = row_c;
                    case (cmd.command)
                        CMD_PUT:
                        begin
                            mem_we       = put_we;
                            mem_waddr    = {ROW_W'(top_reg + row_c), put_wcol};
                            mem_wdata    = put_wdata;
                            cur_col_next = put_col;
                            cur_row_next = row_fin;
                            if (put_scroll)
                            begin
                                // The new bottom row sits one past the old bottom row.
                                top_next        = top_reg + ROW_W'(1);
                                scroll_row_next = ROW_W'(top_reg + 6'(eff_rows));
                                sweep_next      = '0;
                                state_next      = ST_SCROLL;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                                res_cell_next  = 8'd0;
                                res_col_next   = put_col;
                                res_row_next   = row_fin;
                                res_scr_next   = 1'b0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            top_next     = '0;
                            cur_col_next = '0;
                            cur_row_next = '0;
                            sweep_next   = '0;
                            state_next   = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            in_area_next = ({1'b0, cmd.read_row} < eff_rows)
                                        && ({1'b0, cmd.read_col} < eff_cols);
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            res_cell_next  = 8'd0;
                            res_col_next   = col_c;
                            res_row_next   = row_c;
                            res_scr_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_valid_next = 1'b1;
                res_cell_next  = in_area_reg ? rd_data_reg : 8'd0;
                res_col_next   = cur_col_reg;
                res_row_next   = cur_row_reg;
                res_scr_next   = 1'b0;
                state_next     = ST_IDLE;
            end
            ST_SCROLL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {scroll_row_reg, sweep_reg[COL_W-1:0]};
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg[COL_W-1:0] == COL_LAST)
                begin
                    res_valid_next = 1'b1;
                    res_cell_next  = 8'd0;
                    res_col_next   = cur_col_reg;
                    res_row_next   = cur_row_reg;
                    res_scr_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == SWEEP_LAST)
                begin
                    res_valid_next = 1'b1;
                    res_cell_next  = 8'd0;
                    res_col_next   = cur_col_reg;
                    res_row_next   = cur_row_reg;
                    res_scr_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            top_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            res_valid_reg <= 1'b0;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            top_reg       <= top_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLS: cols_reg <= cfg_wdata;
                    CFG_ROWS: rows_reg <= cfg_wdata[6:0];
                    default:  cols_reg <= cols_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_row_reg <= scroll_row_next;
        in_area_reg    <= in_area_next;
        res_cell_reg   <= res_cell_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        res_scr_reg    <= res_scr_next;
    end

    // Text store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: rtl/core/tcce_checker.sv
// Port-level checks for the text console character engine, bound to the top level.
// Depends on tcce_pkg and on the port names of text_console_char_engine.
module tcce_checker
    import tcce_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] cell_char,
    input logic       scrolled
);

    // A result word that is not taken stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped before it was taken");

    // No command word is taken while an earlier result word is stalled.
    a_busy_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("command taken while result is stalled");

    // A scrolling put is never a read, so it carries no cell byte.
    a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && scrolled |-> cell_char == 8'd0)
        else $error("scroll result carries a cell byte");

    // The store sweep only starts once reset is released, so no command word is taken
    // while reset is held.
    a_reset_not_ready: assert property (@(posedge clk)
        !rst_n |-> !cmd_ready)
        else $error("ready during reset");

endmodule

bind text_console_char_engine tcce_checker u_tcce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cell_char (res.cell_char),
    .scrolled  (res.scrolled)
);
